// ----- rtl/core/vn2d_pkg.sv -----
// vn2d_pkg: widths, constants and the pipeline stage type of the 2d vector normalizer
// no dependencies
package vn2d_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int MAG_BITS  = COORD_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam int OUT_BITS  = FRAC_BITS + 2;
    localparam int ACC_BITS  = SUM_BITS + 2 * Q_BITS + 1;
    localparam int NUM_CELLS = FRAC_BITS + 1;
    localparam int SH_BITS   = $clog2(FRAC_BITS + 1);

    typedef logic [ACC_BITS-1:0] t_acc;
    typedef logic [Q_BITS-1:0]   t_q;

    // one component of the running root division: p = s*q*q, r = s*q
    typedef struct packed {
        t_acc tgt;
        t_acc p;
        t_acc r;
        t_q   q;
        logic neg;
    } t_comp;

    typedef struct packed {
        t_acc  sumsq;
        t_comp cx;
        t_comp cy;
        logic  zero;
    } t_stage;

endpackage

// ----- rtl/core/vn2d_if.sv -----
// vn2d_in_if / vn2d_out_if: valid-ready channels of the 2d vector normalizer
// depends on vn2d_pkg
interface vn2d_in_if import vn2d_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface vn2d_out_if import vn2d_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] unit_x;
    logic signed [OUT_BITS-1:0] unit_y;
    modport source (output valid, unit_x, unit_y, input ready);
    modport sink (input valid, unit_x, unit_y, output ready);
endinterface

// ----- rtl/core/vn2d_prep.sv -----
// vn2d_prep: differences, magnitudes and squared length, first pipeline stage
// depends on vn2d_pkg
module vn2d_prep import vn2d_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_adv,
    output logic                         o_take,
    output logic                         o_valid,
    output t_stage                       o_stage
);
    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [MAG_BITS-1:0]         mx, my;
    logic [SQ_BITS-1:0]          sqx, sqy;
    logic                        r_valid;
    t_stage                      r_stage, n_stage;

    always_comb begin
        dx  = DIFF_BITS'(i_end_x) - DIFF_BITS'(i_start_x);
        dy  = DIFF_BITS'(i_end_y) - DIFF_BITS'(i_start_y);
        mx  = dx[DIFF_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
        my  = dy[DIFF_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
        sqx = mx * mx;
        sqy = my * my;
        n_stage        = '0;
        n_stage.sumsq  = ACC_BITS'(sqx) + ACC_BITS'(sqy);
        n_stage.cx.tgt = ACC_BITS'(sqx) << (2 * FRAC_BITS);
        n_stage.cy.tgt = ACC_BITS'(sqy) << (2 * FRAC_BITS);
        n_stage.cx.neg = dx[DIFF_BITS-1];
        n_stage.cy.neg = dy[DIFF_BITS-1];
        n_stage.zero   = (mx == '0) && (my == '0);
    end

    assign o_take = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
        if (o_take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

// ----- rtl/core/vn2d_cell.sv -----
// vn2d_cell: one quotient bit of both components per cell, restoring root division
// depends on vn2d_pkg
module vn2d_cell import vn2d_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SH_BITS-1:0] i_bit,
    input  logic               i_valid,
    input  t_stage             i_stage,
    input  logic               i_adv,
    output logic               o_take,
    output logic               o_valid,
    output t_stage             o_stage
);
    logic   r_valid;
    t_stage r_stage, n_stage;
    t_acc   s_sq, s_lin, tx, ty;

    always_comb begin
        // s*(q+2^b)^2 = s*q^2 + (s*q)*2^(b+1) + s*2^(2b)
        s_sq  = i_stage.sumsq << {i_bit, 1'b0};
        s_lin = i_stage.sumsq << i_bit;
        tx    = i_stage.cx.p + (i_stage.cx.r << (i_bit + 1'b1)) + s_sq;
        ty    = i_stage.cy.p + (i_stage.cy.r << (i_bit + 1'b1)) + s_sq;
        n_stage = i_stage;
        if (tx <= i_stage.cx.tgt) begin
            n_stage.cx.p = tx;
            n_stage.cx.r = i_stage.cx.r + s_lin;
            n_stage.cx.q = i_stage.cx.q | (Q_BITS'(1) << i_bit);
        end
        if (ty <= i_stage.cy.tgt) begin
            n_stage.cy.p = ty;
            n_stage.cy.r = i_stage.cy.r + s_lin;
            n_stage.cy.q = i_stage.cy.q | (Q_BITS'(1) << i_bit);
        end
    end

    assign o_take = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
        if (o_take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

// ----- rtl/core/vector_normalize_2d_core.sv -----
// vector_normalize_2d_core: unit direction of the vector between two points
// depends on vn2d_pkg, vn2d_if, vn2d_prep, vn2d_cell
//
// usage
//   i_in carries start and end point, signed q12.4; o_out returns the unit
//   direction as two signed q2.14 components, truncated toward zero, each in
//   -1.0..1.0. coinciding points give (1.0, 0).
//   one transaction in, exactly one transaction out, in order.
// pipeline
//   one stage for the differences and squared length, 15 cells of the root
//   division (one quotient bit of each component per cell), one output
//   register. one transaction per cycle sustained while o_out is not
//   stalled; every stage is a register.
// reset
//   synchronous active-low reset clears all valid bits; no item state kept.
// stall
//   each stage holds while full and blocked; empty stages keep filling, so
//   i_in.ready falls only once every stage holds an item and o_out is stalled.
module vector_normalize_2d_core import vn2d_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    vn2d_in_if.sink    i_in,
    vn2d_out_if.source o_out
);
    logic   c_valid [NUM_CELLS+1];
    t_stage c_stage [NUM_CELLS+1];
    logic   c_take  [NUM_CELLS+2];
    logic   out_take;
    logic   r_valid;
    logic signed [OUT_BITS-1:0] r_ux, r_uy, n_ux, n_uy;
    t_q     qx, qy;

    localparam t_q Q_ONE = t_q'(1) << FRAC_BITS;

    vn2d_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .i_end_x   (i_in.end_x),
        .i_end_y   (i_in.end_y),
        .i_adv     (c_take[1]),
        .o_take    (c_take[0]),
        .o_valid   (c_valid[0]),
        .o_stage   (c_stage[0])
    );

    assign i_in.ready = c_take[0];

    // the last cell advances into the output register
    assign c_take[NUM_CELLS+1] = out_take;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vn2d_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (SH_BITS'(FRAC_BITS - k)),
            .i_valid (c_valid[k]),
            .i_stage (c_stage[k]),
            .i_adv   (c_take[k+2]),
            .o_take  (c_take[k+1]),
            .o_valid (c_valid[k+1]),
            .o_stage (c_stage[k+1])
        );
    end

    always_comb begin
        qx = (c_stage[NUM_CELLS].cx.q > Q_ONE) ? Q_ONE : c_stage[NUM_CELLS].cx.q;
        qy = (c_stage[NUM_CELLS].cy.q > Q_ONE) ? Q_ONE : c_stage[NUM_CELLS].cy.q;
        n_ux = c_stage[NUM_CELLS].cx.neg ? -OUT_BITS'(qx) : OUT_BITS'(qx);
        n_uy = c_stage[NUM_CELLS].cy.neg ? -OUT_BITS'(qy) : OUT_BITS'(qy);
        if (c_stage[NUM_CELLS].zero) begin
            n_ux = OUT_BITS'(Q_ONE);
            n_uy = '0;
        end
    end

    assign out_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_take) begin
            r_valid <= c_valid[NUM_CELLS];
        end
        if (out_take) begin
            r_ux <= n_ux;
            r_uy <= n_uy;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.unit_x = r_ux;
    assign o_out.unit_y = r_uy;

`ifndef ASSERT_OFF
    a_range_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.unit_x <= $signed(OUT_BITS'(Q_ONE)))
                     && (o_out.unit_x >= -$signed(OUT_BITS'(Q_ONE))))
        else $error("unit_x out of range");
    a_range_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.unit_y <= $signed(OUT_BITS'(Q_ONE)))
                     && (o_out.unit_y >= -$signed(OUT_BITS'(Q_ONE))))
        else $error("unit_y out of range");
    a_stall_only_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif
endmodule
